>>> rtl/core/sfd_pkg.sv
// Shared constants, result codes and types of the SLIP frame decoder.
`default_nettype none

package sfd_pkg;

    localparam int BYTE_W = 8;
    localparam int KIND_W = 3;
    localparam int LEN_W  = 12;
    localparam int MAX_FRAME_BYTES_DEF = 2048;

    localparam logic [BYTE_W-1:0] SLIP_END     = 8'hC0;
    localparam logic [BYTE_W-1:0] SLIP_ESC     = 8'hDB;
    localparam logic [BYTE_W-1:0] SLIP_ESC_END = 8'hDC;
    localparam logic [BYTE_W-1:0] SLIP_ESC_ESC = 8'hDD;

    localparam logic [KIND_W-1:0] KIND_DATA     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_ACCEPT   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_BADLEN   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_BADESC   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_OVERFLOW = 3'd4;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] data_byte;
        logic [LEN_W-1:0]  frame_length;
    } sfd_result_t;

endpackage

`default_nettype wire

>>> rtl/core/sfd_in_reg.sv
// Input register that holds one raw byte until the decoder takes it.
`default_nettype none

module sfd_in_reg
    import sfd_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [BYTE_W-1:0] in_byte,
    input  wire logic              advance,
    output logic                   hold_valid,
    output logic [BYTE_W-1:0]      hold_byte
);

    logic              valid_reg;
    logic              valid_next;
    logic [BYTE_W-1:0] byte_reg;

    assign in_ready   = !valid_reg || advance;
    assign hold_valid = valid_reg;
    assign hold_byte  = byte_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            byte_reg <= in_byte;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/sfd_decode.sv
// Framing state, byte count and per-byte decode of the SLIP stream.
`default_nettype none

module sfd_decode
    import sfd_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              advance,
    input  wire logic [BYTE_W-1:0] hold_byte,
    output logic                   res_valid,
    output sfd_result_t            res
);

    localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_FRAME_BYTES);

    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_FRAME  = 2'd1;
    localparam logic [1:0] PH_ESCAPE = 2'd2;
    localparam logic [1:0] PH_HUNT   = 2'd3;

    logic [1:0]             phase_reg;
    logic [1:0]             phase_next;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic [CNT_W+LEN_W-1:0] count_wide;
    logic                   put;
    logic [BYTE_W-1:0]      put_byte;

    assign count_wide = {{LEN_W{1'b0}}, count_reg};

    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        res_valid  = 1'b0;
        res        = '0;
        put        = 1'b0;
        put_byte   = hold_byte;
        case (phase_reg)
            PH_IDLE, PH_FRAME:
            begin
                if (hold_byte == SLIP_END)
                begin
                    phase_next = PH_IDLE;
                    count_next = '0;
                    if (count_reg != '0)
                    begin
                        res_valid        = 1'b1;
                        res.kind         = (count_reg[1:0] == 2'd0) ? KIND_ACCEPT
                                                                    : KIND_BADLEN;
                        res.frame_length = count_wide[LEN_W-1:0];
                    end
                end
                else if (hold_byte == SLIP_ESC)
                begin
                    phase_next = PH_ESCAPE;
                end
                else
                begin
                    put = 1'b1;
                end
            end
            PH_ESCAPE:
            begin
                if (hold_byte == SLIP_ESC_END)
                begin
                    put      = 1'b1;
                    put_byte = SLIP_END;
                end
                else if (hold_byte == SLIP_ESC_ESC)
                begin
                    put      = 1'b1;
                    put_byte = SLIP_ESC;
                end
                else
                begin
                    phase_next = PH_HUNT;
                    res_valid  = 1'b1;
                    res.kind   = KIND_BADESC;
                end
            end
            default:
            begin
                if (hold_byte == SLIP_END)
                begin
                    phase_next = PH_IDLE;
                    count_next = '0;
                end
            end
        endcase
        if (put)
        begin
            res_valid = 1'b1;
            if (count_reg != CNT_MAX)
            begin
                count_next    = count_reg + 1'b1;
                phase_next    = PH_FRAME;
                res.kind      = KIND_DATA;
                res.data_byte = put_byte;
            end
            else
            begin
                phase_next = PH_HUNT;
                res.kind   = KIND_OVERFLOW;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            count_reg <= '0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_MAX)
        else $error("byte count passed the frame limit");

    a_abort_hunts: assert property (@(posedge clk) disable iff (!rst_n)
        advance && res_valid && (res.kind == KIND_BADESC || res.kind == KIND_OVERFLOW)
        |=> phase_reg == PH_HUNT)
        else $error("abort did not enter error hunt");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        advance && res_valid && (res.kind == KIND_ACCEPT || res.kind == KIND_BADLEN)
        |=> count_reg == '0 && phase_reg == PH_IDLE)
        else $error("frame end did not clear the count");

    a_data_counts: assert property (@(posedge clk) disable iff (!rst_n)
        advance && res_valid && res.kind == KIND_DATA
        |=> count_reg == $past(count_reg) + 1'b1)
        else $error("data byte not counted");
`endif

endmodule

`default_nettype wire

>>> rtl/core/sfd_out_reg.sv
// Result register that holds one decoded request until the sink takes it.
`default_nettype none

module sfd_out_reg
    import sfd_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  load,
    input  wire sfd_result_t res,
    output logic       room,
    output logic       out_valid,
    input  wire logic  out_ready,
    output sfd_result_t out_res
);

    logic        valid_reg;
    logic        valid_next;
    sfd_result_t res_reg;

    assign room      = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (room)
        begin
            valid_next = load;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (room && load)
        begin
            res_reg <= res;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/slip_frame_decoder.sv
// Top level of the SLIP frame decoder with stream ports.
`default_nettype none

// Decodes a SLIP byte stream at one raw byte per clock cycle while the
// sink keeps up. Each request passes an input register, a decode against
// the framing state and the byte count, and a result register, and a new
// byte can be taken every cycle while the result register has room.
// Decoded payload bytes come out one per request; a
// non-empty frame ends with an accept or a length reject carrying its byte
// count, and a bad escape or a frame longer than MAX_FRAME_BYTES gives an
// abort, after which bytes are dropped until the next END. Bytes that cause
// no result, such as ESC and END of an empty frame, are absorbed without
// output.
module slip_frame_decoder
    import sfd_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // in_byte
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,   // data_byte, frame_length, zero pad
    output logic [2:0]       m_axis_tuser    // out_kind
);

    logic              hold_valid;
    logic [BYTE_W-1:0] hold_byte;
    logic              advance;
    logic              room;
    logic              res_valid;
    sfd_result_t       res;
    sfd_result_t       out_res;

    assign advance = hold_valid && room;

    sfd_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_byte    (s_axis_tdata),
        .advance    (advance),
        .hold_valid (hold_valid),
        .hold_byte  (hold_byte)
    );

    sfd_decode #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .hold_byte (hold_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    sfd_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance && res_valid),
        .res       (res),
        .room      (room),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (out_res)
    );

    assign m_axis_tuser = out_res.kind;
    assign m_axis_tdata = {4'd0, out_res.frame_length, out_res.data_byte};

endmodule

`default_nettype wire
